// File: design/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
package qrs_pkg;

  // Default coefficient width
  localparam int unsigned COEF_WIDTH_DEF = 16;

  // Root class codes
  typedef logic [1:0] root_class_t;
  localparam root_class_t CLASS_NONE    = 2'd0;  // a is zero
  localparam root_class_t CLASS_COMPLEX = 2'd1;  // negative discriminant
  localparam root_class_t CLASS_DOUBLE  = 2'd2;  // zero discriminant
  localparam root_class_t CLASS_TWO     = 2'd3;  // positive discriminant

endpackage

// File: design/qrs_disc.sv
// Two-stage discriminant unit: products, then b*b - 4ac and classification.
module qrs_disc #(
  parameter int unsigned W = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [W-1:0]  a_i,
  input  logic signed [W-1:0]  b_i,
  input  logic signed [W-1:0]  c_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qrs_pkg::root_class_t cls_o,
  output logic [2*W:0]         disc_o,
  output logic signed [W-1:0]  a_o,
  output logic signed [W-1:0]  b_o
);

  localparam int unsigned PW = 2 * W;
  localparam int unsigned XW = 2 * W + 3;

  logic v0_q, v1_q;
  logic ld0, ld1;

  logic signed [W-1:0]  a0_q, b0_q;
  logic signed [PW-1:0] bb_d, ac_d, bb_q, ac_q;
  logic signed [XW-1:0] disc_x;
  qrs_pkg::root_class_t cls_d, cls_q;
  logic [2*W:0]         disc_d, disc_q;
  logic signed [W-1:0]  a1_q, b1_q;

  // Stage advance
  assign ld1        = !v1_q || out_ready_i;
  assign ld0        = !v0_q || ld1;
  assign in_ready_o = ld0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (ld0) v0_q <= in_valid_i;
      if (ld1) v1_q <= v0_q;
    end
  end

  // Stage 0: products
  assign bb_d = b_i * b_i;
  assign ac_d = a_i * c_i;

  always_ff @(posedge clk_i) begin
    if (ld0 && in_valid_i) begin
      a0_q <= a_i;
      b0_q <= b_i;
      bb_q <= bb_d;
      ac_q <= ac_d;
    end
  end

  // Stage 1: discriminant and class
  always_comb begin
    disc_x = $signed({{3{bb_q[PW-1]}}, bb_q}) - $signed({ac_q[PW-1], ac_q, 2'b00});
    if (a0_q == '0) begin
      cls_d = qrs_pkg::CLASS_NONE;
    end else if (disc_x[XW-1]) begin
      cls_d = qrs_pkg::CLASS_COMPLEX;
    end else if (disc_x == '0) begin
      cls_d = qrs_pkg::CLASS_DOUBLE;
    end else begin
      cls_d = qrs_pkg::CLASS_TWO;
    end
    disc_d = (cls_d == qrs_pkg::CLASS_TWO) ? disc_x[2*W:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ld1 && v0_q) begin
      cls_q  <= cls_d;
      disc_q <= disc_d;
      a1_q   <= a0_q;
      b1_q   <= b0_q;
    end
  end

  assign out_valid_o = v1_q;
  assign cls_o       = cls_q;
  assign disc_o      = disc_q;
  assign a_o         = a1_q;
  assign b_o         = b1_q;

endmodule

// File: design/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage, with exactness flag.
module qrs_sqrt #(
  parameter int unsigned W   = qrs_pkg::COEF_WIDTH_DEF,
  parameter int unsigned SBW = 2 * qrs_pkg::COEF_WIDTH_DEF + 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2*W:0]   disc_i,
  input  logic [SBW-1:0] sb_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [W:0]     root_o,
  output logic           exact_o,
  output logic [SBW-1:0] sb_o
);

  localparam int unsigned N  = W + 1;
  localparam int unsigned DW = 2 * W + 1;
  localparam int unsigned TW = 2 * W + 3;

  logic [N-1:0]   v_q;
  logic [N:0]     ld;
  logic [DW-1:0]  rem_q  [N];
  logic [W:0]     root_q [N];
  logic [SBW-1:0] sb_q   [N];

  assign ld[N]      = out_ready_i;
  assign in_ready_o = ld[0];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int unsigned K = N - 1 - j;
    logic           vin;
    logic [DW-1:0]  rem_in, rem_d;
    logic [W:0]     root_in, root_d;
    logic [SBW-1:0] sb_in;
    logic [TW-1:0]  trial;
    logic           take;

    if (j == 0) begin : g_first
      assign vin     = in_valid_i;
      assign rem_in  = disc_i;
      assign root_in = '0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign vin     = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign sb_in   = sb_q[j-1];
    end

    assign ld[j] = !v_q[j] || ld[j+1];

    // Trial (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
    always_comb begin
      trial  = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
      take   = trial <= TW'(rem_in);
      rem_d  = take ? DW'(TW'(rem_in) - trial) : rem_in;
      root_d = root_in;
      if (take) root_d[K] = 1'b1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (ld[j]) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[j] && vin) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        sb_q[j]   <= sb_in;
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign root_o      = root_q[N-1];
  assign exact_o     = (rem_q[N-1] == '0);
  assign sb_o        = sb_q[N-1];

endmodule

// File: design/qrs_div.sv
// Pipelined truncating divide of both root numerators by 2a, one quotient bit per stage.
module qrs_div #(
  parameter int unsigned W = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [W:0]           root_i,
  input  logic                 exact_i,
  input  qrs_pkg::root_class_t cls_i,
  input  logic signed [W-1:0]  a_i,
  input  logic signed [W-1:0]  b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qrs_pkg::root_class_t cls_o,
  output logic signed [W:0]    plus_o,
  output logic signed [W:0]    minus_o
);

  localparam int unsigned NW  = W + 3;
  localparam int unsigned QW  = W + 2;
  localparam int unsigned DVW = W + 1;
  localparam int unsigned N   = QW + 1;

  // Fold divisor sign and inexact sqrt into {negate, magnitude}
  function automatic logic [QW:0] fold(input logic signed [NW-1:0] n0,
                                       input logic aneg, input logic exact);
    logic signed [NW-1:0] v;
    logic signed [NW-1:0] m;
    v = aneg ? (exact ? -n0 : NW'(-n0 - NW'(1))) : n0;
    if (v[NW-1]) begin
      m = exact ? -v : NW'(-v - NW'(1));
      return {1'b1, m[QW-1:0]};
    end
    return {1'b0, v[QW-1:0]};
  endfunction

  logic [N-1:0]         v_q;
  logic [N:0]           ld;
  logic [QW-1:0]        mag_q [N][2];
  logic                 neg_q [N][2];
  logic [QW-1:0]        quo_q [N][2];
  logic [DVW-1:0]       rem_q [N][2];
  logic [DVW-1:0]       dv_q  [N];
  qrs_pkg::root_class_t cls_q [N];

  assign ld[N]      = out_ready_i;
  assign in_ready_o = ld[0];

  // Stage 0: numerators and divisor magnitude
  logic signed [NW-1:0] bx, sx, np, nm;
  logic signed [DVW-1:0] a2;
  logic [QW:0] fp, fm;
  logic [DVW-1:0] dv_d;

  always_comb begin
    bx   = NW'(b_i);
    sx   = $signed({2'b00, root_i});
    np   = sx - bx;
    nm   = exact_i ? NW'(-bx - sx) : NW'(-bx - sx - NW'(1));
    fp   = fold(np, a_i[W-1], exact_i);
    fm   = fold(nm, a_i[W-1], exact_i);
    a2   = {a_i, 1'b0};
    dv_d = a_i[W-1] ? DVW'(-a2) : DVW'(a2);
  end

  assign ld[0] = !v_q[0] || ld[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (ld[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0] && in_valid_i) begin
      mag_q[0][0] <= fp[QW-1:0];
      neg_q[0][0] <= fp[QW];
      mag_q[0][1] <= fm[QW-1:0];
      neg_q[0][1] <= fm[QW];
      quo_q[0][0] <= '0;
      quo_q[0][1] <= '0;
      rem_q[0][0] <= '0;
      rem_q[0][1] <= '0;
      dv_q[0]     <= dv_d;
      cls_q[0]    <= cls_i;
    end
  end

  // Divide stages
  for (genvar j = 1; j < N; j++) begin : g_stage
    localparam int unsigned K = QW - j;

    assign ld[j] = !v_q[j] || ld[j+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (ld[j]) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[j] && v_q[j-1]) begin
        dv_q[j]  <= dv_q[j-1];
        cls_q[j] <= cls_q[j-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DVW:0]   cand;
      logic           ge;
      logic [DVW-1:0] rem_d;
      logic [QW-1:0]  quo_d;

      always_comb begin
        cand  = {rem_q[j-1][l], mag_q[j-1][l][K]};
        ge    = cand >= {1'b0, dv_q[j-1]};
        rem_d = ge ? DVW'(cand - {1'b0, dv_q[j-1]}) : cand[DVW-1:0];
        quo_d = quo_q[j-1][l];
        if (ge) quo_d[K] = 1'b1;
      end

      always_ff @(posedge clk_i) begin
        if (ld[j] && v_q[j-1]) begin
          mag_q[j][l] <= mag_q[j-1][l];
          neg_q[j][l] <= neg_q[j-1][l];
          quo_q[j][l] <= quo_d;
          rem_q[j][l] <= rem_d;
        end
      end
    end
  end

  // Apply sign, zero for classes without real roots
  logic [QW-1:0] qp, qm;
  logic          real_roots;

  always_comb begin
    qp = neg_q[N-1][0] ? QW'(-quo_q[N-1][0]) : quo_q[N-1][0];
    qm = neg_q[N-1][1] ? QW'(-quo_q[N-1][1]) : quo_q[N-1][1];
    real_roots = (cls_q[N-1] == qrs_pkg::CLASS_TWO) ||
                 (cls_q[N-1] == qrs_pkg::CLASS_DOUBLE);
  end

  assign out_valid_o = v_q[N-1];
  assign cls_o       = cls_q[N-1];
  assign plus_o      = real_roots ? $signed(qp[W:0]) : '0;
  assign minus_o     = real_roots ? $signed(qm[W:0]) : '0;

endmodule

// File: design/quadratic_root_solver.sv
// Quadratic root solver top level: discriminant, square root and divide pipelines.
//
// Input channel (in_valid_i/in_ready_o) carries one coefficient set a, b, c per
// transfer; output channel (out_valid_o/out_ready_i) returns the root class and
// the two roots truncated toward zero, one result per input, in order.
// Class: not quadratic, complex, double root, two real roots; roots read zero
// for the first two classes.
// Stages in order:
// two discriminant stages, COEF_WIDTH+1 square root stages (one root bit each),
// one numerator stage and COEF_WIDTH+2 divide stages (one quotient bit each).
// Throughput: one coefficient set per cycle while out_ready_i does not hold the output.
// Every stage has its own valid bit and loads when it is empty or its successor
// moves, so bubbles close up under backpressure and the input keeps taking
// transfers until the whole pipeline is full. A stalled result holds steady.
// Reset clears all valid bits, so the block is ready as soon as reset is released.
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COEF_WIDTH-1:0] coef_a_i,
  input  logic signed [COEF_WIDTH-1:0] coef_b_i,
  input  logic signed [COEF_WIDTH-1:0] coef_c_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   root_class_o,
  output logic signed [COEF_WIDTH:0]   root_plus_o,
  output logic signed [COEF_WIDTH:0]   root_minus_o
);

  localparam int unsigned W   = COEF_WIDTH;
  localparam int unsigned SBW = 2 * W + 2;

  // Discriminant to square root
  logic                 d_valid, d_ready;
  qrs_pkg::root_class_t d_cls;
  logic [2*W:0]         d_disc;
  logic signed [W-1:0]  d_a, d_b;

  // Square root to divide
  logic                 s_valid, s_ready;
  logic [W:0]           s_root;
  logic                 s_exact;
  logic [SBW-1:0]       s_sb;
  qrs_pkg::root_class_t s_cls;
  logic signed [W-1:0]  s_a, s_b;

  qrs_pkg::root_class_t o_cls;

  qrs_disc #(.W(W)) u_disc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_i         (coef_a_i),
    .b_i         (coef_b_i),
    .c_i         (coef_c_i),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .cls_o       (d_cls),
    .disc_o      (d_disc),
    .a_o         (d_a),
    .b_o         (d_b)
  );

  qrs_sqrt #(.W(W), .SBW(SBW)) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .disc_i      (d_disc),
    .sb_i        ({d_cls, d_a, d_b}),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .root_o      (s_root),
    .exact_o     (s_exact),
    .sb_o        (s_sb)
  );

  assign s_cls = s_sb[SBW-1 -: 2];
  assign s_a   = $signed(s_sb[2*W-1 -: W]);
  assign s_b   = $signed(s_sb[W-1:0]);

  qrs_div #(.W(W)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .root_i      (s_root),
    .exact_i     (s_exact),
    .cls_i       (s_cls),
    .a_i         (s_a),
    .b_i         (s_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cls_o       (o_cls),
    .plus_o      (root_plus_o),
    .minus_o     (root_minus_o)
  );

  assign root_class_o = o_cls;

  // An empty output stage lets every stage above it move
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while output stage empty");

  // No real roots means zero root fields
  a_zero_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_class_o == qrs_pkg::CLASS_NONE ||
                    root_class_o == qrs_pkg::CLASS_COMPLEX)
    |-> (root_plus_o == '0 && root_minus_o == '0))
    else $error("nonzero roots for a class without real roots");

  // Double root gives the same value on both fields
  a_double_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_class_o == qrs_pkg::CLASS_DOUBLE
    |-> root_plus_o == root_minus_o)
    else $error("double root fields differ");

endmodule
